[hw/rtl/gemc_pkg.sv]
`timescale 1ns / 1ps

package gemc_pkg;

    localparam int BUTTONS_W = 10;
    localparam int SAMPLE_W  = 16;
    localparam int AXES      = 6;
    localparam int MAG_W     = SAMPLE_W + 1;
    localparam int DZ_W      = 15;
    localparam int IN_W      = 112;
    localparam int OUT_W     = 48;

    localparam logic [DZ_W-1:0] DEADZONE_RESET = 15'd33;

    // axis order as on the input: left thumb, right thumb, cursor pad
    localparam int AX_LH = 0;
    localparam int AX_LV = 1;
    localparam int AX_RH = 2;
    localparam int AX_RV = 3;
    localparam int AX_CH = 4;
    localparam int AX_CV = 5;

    localparam int BTN_L1   = 4;
    localparam int BTN_R1   = 5;
    localparam int BTN_L2   = 6;
    localparam int BTN_R2   = 7;
    localparam int BTN_NINE = 8;

    localparam logic [4:0] RIGHT_FREE = 5'd21;
    localparam logic [3:0] LEFT_FREE  = 4'd15;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_HOLD    = 2'd1,
        EV_RELEASE = 2'd2,
        EV_IDLE    = 2'd3
    } ev_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic [BUTTONS_W-1:0] buttons;
        logic [AXES-1:0]      act;
    } gemc_state_t;

    // indexed by {R2, R1, L2, L1}
    localparam logic [3:0] SHOULDER_CODE [16] = '{
        4'd15, 4'd0, 4'd1, 4'd4, 4'd2, 4'd6, 4'd8, 4'd10,
        4'd3, 4'd7, 4'd9, 4'd11, 4'd5, 4'd12, 4'd13, 4'd14
    };

    function automatic ev_t transition(input logic cur, input logic prev);
        ev_t ev;
        case ({cur, prev})
            2'b10:   ev = EV_PRESS;
            2'b11:   ev = EV_HOLD;
            2'b01:   ev = EV_RELEASE;
            default: ev = EV_IDLE;
        endcase
        return ev;
    endfunction

endpackage

[hw/rtl/gemc_axis_sel.sv]
`timescale 1ns / 1ps

module gemc_axis_sel
    import gemc_pkg::*;
(
    input  logic [DZ_W-1:0] deadzone,
    input  sample_t         samples [AXES],
    output logic [AXES-1:0] act
);

    logic [MAG_W-1:0] mag [AXES];
    logic [AXES-1:0]  raw;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            // magnitude at 17 bits so that the most negative sample fits
            if (samples[i][SAMPLE_W-1])
                mag[i] = {1'b0, ~samples[i]} + MAG_W'(1);
            else
                mag[i] = {1'b0, samples[i]};
            raw[i] = mag[i] > {{(MAG_W-DZ_W){1'b0}}, deadzone};
        end
    end

    // within a pair the larger axis wins, a tie keeps horizontal
    always_comb
    begin
        for (int p = 0; p < AXES / 2; p++)
        begin
            act[2*p]   = raw[2*p] && !(raw[2*p+1] && (mag[2*p] < mag[2*p+1]));
            act[2*p+1] = raw[2*p+1] && !(raw[2*p] && (mag[2*p] >= mag[2*p+1]));
        end
    end

endmodule

[hw/rtl/gemc_event.sv]
`timescale 1ns / 1ps

module gemc_event
    import gemc_pkg::*;
(
    input  gemc_state_t cur,
    input  gemc_state_t prev,
    input  sample_t     samples [AXES],
    output logic [4:0]  right_mode,
    output logic [3:0]  left_mode,
    output logic [3:0]  finger_mode,
    output sample_t     right_value,
    output sample_t     left_value
);

    localparam int R_ENTRIES = 7;
    localparam int R_BTNS    = 5;
    localparam int L_ENTRIES = 5;
    localparam int RIGHT_BTN [R_BTNS] = '{0, 1, 2, 3, 9};
    localparam int LEFT_AX [L_ENTRIES-1] = '{AX_LH, AX_LV, AX_CH, AX_CV};

    ev_t        r_ev [R_ENTRIES];
    ev_t        l_ev [L_ENTRIES];
    logic [3:0] shoulder_idx;

    always_comb
    begin
        for (int k = 0; k < R_BTNS; k++)
            r_ev[k] = transition(cur.buttons[RIGHT_BTN[k]], prev.buttons[RIGHT_BTN[k]]);
        r_ev[5] = transition(cur.act[AX_RH], prev.act[AX_RH]);
        r_ev[6] = transition(cur.act[AX_RV], prev.act[AX_RV]);

        l_ev[0] = transition(cur.buttons[BTN_NINE], prev.buttons[BTN_NINE]);
        for (int j = 1; j < L_ENTRIES; j++)
            l_ev[j] = transition(cur.act[LEFT_AX[j-1]], prev.act[LEFT_AX[j-1]]);
    end

    // priority chains: walked from the back so the first engaged entry wins
    always_comb
    begin
        right_mode  = RIGHT_FREE;
        right_value = '0;
        for (int k = R_ENTRIES - 1; k >= 0; k--)
        begin
            if (r_ev[k] != EV_IDLE)
            begin
                right_mode = 5'(3 * k) + 5'(r_ev[k]);
                if (k >= R_BTNS && r_ev[k] != EV_RELEASE)
                    right_value = samples[(k >= R_BTNS) ? AX_RH + k - R_BTNS : AX_RH];
                else
                    right_value = '0;
            end
        end
    end

    always_comb
    begin
        left_mode  = LEFT_FREE;
        left_value = '0;
        for (int j = L_ENTRIES - 1; j >= 0; j--)
        begin
            if (l_ev[j] != EV_IDLE)
            begin
                left_mode = 4'(3 * j) + 4'(l_ev[j]);
                if (j >= 1 && l_ev[j] != EV_RELEASE)
                    left_value = samples[LEFT_AX[(j >= 1) ? j - 1 : 0]];
                else
                    left_value = '0;
            end
        end
    end

    assign shoulder_idx = {cur.buttons[BTN_R2], cur.buttons[BTN_R1],
                           cur.buttons[BTN_L2], cur.buttons[BTN_L1]};
    assign finger_mode  = SHOULDER_CODE[shoulder_idx];

endmodule

[hw/rtl/gamepad_event_mode_classifier.sv]
`timescale 1ns / 1ps

// Classifies one controller report per word into press/hold/release/free codes for the
// right and left groups, a shoulder combination code and the selected axis samples. A word
// is held in an input register, passes through the deadzone, pair selection and priority
// logic and lands in the output register. One word is taken every cycle while the output
// is drained; the previous-report state is updated
// as each word moves into the output register. The deadzone is written through cfg_wr_en
// and should only change while no word is in flight.
module gamepad_event_mode_classifier
    import gemc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_wr_en,
    input  logic [DZ_W-1:0]  cfg_wr_data,    // deadzone

    input  logic             s_tvalid,
    output logic             s_tready,
    // buttons, left_horz, left_vert, right_horz, right_vert, pad_horz, pad_vert, zero pad
    input  logic [IN_W-1:0]  s_tdata,

    output logic             m_tvalid,
    input  logic             m_tready,
    // right_mode, left_mode, finger_mode, right_value, left_value, zero pad
    output logic [OUT_W-1:0] m_tdata
);

    logic [DZ_W-1:0]      deadzone_reg;
    logic                 in_valid_reg;
    logic [BUTTONS_W-1:0] buttons_reg;
    sample_t              samples_reg [AXES];
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;
    logic [OUT_W-1:0]     out_data_next;
    gemc_state_t          prev_reg;
    gemc_state_t          cur;
    logic [AXES-1:0]      act;
    logic                 advance;

    logic [4:0] right_mode;
    logic [3:0] left_mode;
    logic [3:0] finger_mode;
    sample_t    right_value;
    sample_t    left_value;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg  <= DEADZONE_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                deadzone_reg <= cfg_wr_data;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                prev_reg      <= cur;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            buttons_reg <= s_tdata[BUTTONS_W-1:0];
            for (int i = 0; i < AXES; i++)
                samples_reg[i] <= s_tdata[BUTTONS_W + i*SAMPLE_W +: SAMPLE_W];
        end
        if (advance)
            out_data_reg <= out_data_next;
    end

    gemc_axis_sel u_axis_sel (
        .deadzone (deadzone_reg),
        .samples  (samples_reg),
        .act      (act)
    );

    assign cur.buttons = buttons_reg;
    assign cur.act     = act;

    gemc_event u_event (
        .cur         (cur),
        .prev        (prev_reg),
        .samples     (samples_reg),
        .right_mode  (right_mode),
        .left_mode   (left_mode),
        .finger_mode (finger_mode),
        .right_value (right_value),
        .left_value  (left_value)
    );

    assign out_data_next = {3'b000, left_value, right_value, finger_mode, left_mode, right_mode};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[hw/rtl/gemc_checker.sv]
`timescale 1ns / 1ps

module gemc_checker
    import gemc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // an accepted word leads to a valid word at the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("accepted word did not reach the output");

    // a right value only accompanies a right axis press or hold
    a_right_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[28:13] != 16'd0) |->
            (m_tdata[4:0] == 5'd15) || (m_tdata[4:0] == 5'd16) ||
            (m_tdata[4:0] == 5'd18) || (m_tdata[4:0] == 5'd19))
        else $error("right value without right axis press or hold");

    // a left value only accompanies a left or cursor axis press or hold
    a_left_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[44:29] != 16'd0) |->
            (m_tdata[8:5] == 4'd3) || (m_tdata[8:5] == 4'd4) ||
            (m_tdata[8:5] == 4'd6) || (m_tdata[8:5] == 4'd7) ||
            (m_tdata[8:5] == 4'd9) || (m_tdata[8:5] == 4'd10) ||
            (m_tdata[8:5] == 4'd12) || (m_tdata[8:5] == 4'd13))
        else $error("left value without left axis press or hold");

endmodule

bind gamepad_event_mode_classifier gemc_checker u_gemc_checker (.*);
